// ----- rtl/bfc_pkg.sv -----
// shared types and constants for the box frustum cull block
package bfc_pkg;

  localparam int COORD_W     = 16;
  localparam int PROD_W      = 32;
  localparam int SUM_W       = 33;
  localparam int OFFSET_SHIFT = 14;
  localparam int CFG_REGS    = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] d;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nx;
  } plane_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] d;
    logic signed [PROD_W-1:0]  px;
    logic signed [PROD_W-1:0]  py;
    logic signed [PROD_W-1:0]  pz;
  } prod_t;

endpackage

// ----- rtl/bfc_plane_file.sv -----
// frustum plane configuration registers
module bfc_plane_file import bfc_pkg::*; #(
  parameter int PLANE_COUNT = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output plane_t                 planes [PLANE_COUNT]
);

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    if (p < CFG_REGS) begin : g_reg
      plane_t plane;
      always_ff @(posedge clk) begin
        if (rst) begin
          plane <= '0;
        end else if (wr_en && wr_index == CFG_INDEX_W'(p)) begin
          plane <= plane_t'(wr_data);
        end
      end
      assign planes[p] = plane;
    end else begin : g_zero
      // planes without a register never reject
      assign planes[p] = '0;
    end
  end

endmodule

// ----- rtl/bfc_mult_stage.sv -----
// near corner selection and per-plane products, first pipeline stage
module bfc_mult_stage import bfc_pkg::*; #(
  parameter int PLANE_COUNT = 6
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   up_valid,
  output logic   up_ready,
  input  vec_t   box_min,
  input  vec_t   box_max,
  input  plane_t planes [PLANE_COUNT],
  output logic   down_valid,
  input  logic   down_ready,
  output prod_t  prod [PLANE_COUNT]
);

  logic  valid;
  prod_t prod_next [PLANE_COUNT];

  assign up_ready   = !valid || down_ready;
  assign down_valid = valid;

  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      coord_t sx, sy, sz;
      // strictly positive component picks the minimum
      sx = (!planes[p].nx[COORD_W-1] && planes[p].nx != '0) ? box_min.x : box_max.x;
      sy = (!planes[p].ny[COORD_W-1] && planes[p].ny != '0) ? box_min.y : box_max.y;
      sz = (!planes[p].nz[COORD_W-1] && planes[p].nz != '0) ? box_min.z : box_max.z;
      prod_next[p].d  = planes[p].d;
      prod_next[p].px = PROD_W'(planes[p].nx) * PROD_W'(sx);
      prod_next[p].py = PROD_W'(planes[p].ny) * PROD_W'(sy);
      prod_next[p].pz = PROD_W'(planes[p].nz) * PROD_W'(sz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      prod <= prod_next;
    end
  end

endmodule

// ----- rtl/bfc_sum_stage.sv -----
// plane distance sums, second pipeline stage
module bfc_sum_stage import bfc_pkg::*; #(
  parameter int PLANE_COUNT = 6
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  prod_t prod [PLANE_COUNT],
  output logic  down_valid,
  input  logic  down_ready,
  output sum_t  sum [PLANE_COUNT]
);

  logic valid;
  sum_t sum_next [PLANE_COUNT];

  assign up_ready   = !valid || down_ready;
  assign down_valid = valid;

  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      sum_next[p] = SUM_W'(prod[p].px) + SUM_W'(prod[p].py) + SUM_W'(prod[p].pz)
                  + (SUM_W'(prod[p].d) <<< OFFSET_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      sum <= sum_next;
    end
  end

endmodule

// ----- rtl/box_frustum_cull.sv -----
// top level of the box frustum cull block
//
// Tests each axis-aligned box against PLANE_COUNT frustum planes and returns
// one visibility bit per box. A new box request is taken every cycle while
// in_ready is high; it drops only when a stalled output has filled every
// stage. The three register stages
// are: near corner select and 16x16 products (three multipliers per plane),
// per-plane sum with the scaled offset, then the sign test and the AND over
// all planes in the output register. A stall on the output holds every stage
// and fills bubbles in place. The user is to write plane registers through
// wr_en/wr_index/wr_data only while no box is in flight; the block does not
// enforce this. Indexes beyond the plane registers are ignored.
module box_frustum_cull import bfc_pkg::*; #(
  parameter int PLANE_COUNT = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [15:0]     box_min_x,
  input  logic signed [15:0]     box_min_y,
  input  logic signed [15:0]     box_min_z,
  input  logic signed [15:0]     box_max_x,
  input  logic signed [15:0]     box_max_y,
  input  logic signed [15:0]     box_max_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   visible
);

  plane_t planes [PLANE_COUNT];
  prod_t  prod [PLANE_COUNT];
  sum_t   sum [PLANE_COUNT];
  vec_t   box_min, box_max;
  logic   mult_valid, sum_valid;
  logic   sum_ready, out_stage_ready;
  logic   visible_next;

  assign box_min = '{x: box_min_x, y: box_min_y, z: box_min_z};
  assign box_max = '{x: box_max_x, y: box_max_y, z: box_max_z};

  bfc_plane_file #(.PLANE_COUNT(PLANE_COUNT)) u_planes (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .planes   (planes)
  );

  bfc_mult_stage #(.PLANE_COUNT(PLANE_COUNT)) u_mult (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (in_valid),
    .up_ready   (in_ready),
    .box_min    (box_min),
    .box_max    (box_max),
    .planes     (planes),
    .down_valid (mult_valid),
    .down_ready (sum_ready),
    .prod       (prod)
  );

  bfc_sum_stage #(.PLANE_COUNT(PLANE_COUNT)) u_sum (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (mult_valid),
    .up_ready   (sum_ready),
    .prod       (prod),
    .down_valid (sum_valid),
    .down_ready (out_stage_ready),
    .sum        (sum)
  );

  assign out_stage_ready = !out_valid || out_ready;

  // a plane rejects when its sum is above zero
  always_comb begin
    visible_next = 1'b1;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      if (!sum[p][SUM_W-1] && sum[p] != '0) begin
        visible_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_stage_ready) begin
      out_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && out_stage_ready) begin
      visible <= visible_next;
    end
  end

endmodule

// ----- rtl/bfc_checker.sv -----
// port-level checks for the box frustum cull block
module bfc_checker import bfc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic visible
);

  // a request taken while the output keeps flowing reaches out_valid
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result did not arrive after three free cycles");

  // the pipeline only pushes back when the output stalls
  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is free");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visible))
    else $error("stalled result changed");

endmodule

bind box_frustum_cull bfc_checker u_bfc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .visible   (visible)
);
